>>> design/lrpd_pkg.sv
// Package for the lidar ring point densifier: widths, commands, point types,
// reset constants and the interpolation step. No dependencies.
package lrpd_pkg;

    localparam int COORD_W      = 32;
    localparam int THR_W        = 31;
    localparam int RING_W       = 4;
    localparam int RATIO_DEF    = 4;
    localparam int RING_CNT_DEF = 16;
    localparam int RING_SLOTS   = 16;

    localparam logic [THR_W-1:0] THR_RESET = 31'd65536;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // base entry: x, y, z, brightness, stamp
    localparam int BASE_W = 5 * COORD_W;
    // head entry: x, y, z, brightness
    localparam int HEAD_W = 4 * COORD_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] b;
    } pt_t;

    typedef struct packed {
        pt_t               pt;
        logic [RING_W-1:0] ring;
        logic [31:0]       stamp;
        logic              syn;
        logic              last;
    } res_t;

    // base + round(d*i/ratio), halves away from zero; d is exact 33 bits.
    // Ratio 3: with n = hi*2^18 + lo and 2^18 = 3*87381 + 1,
    // n/3 = hi*87381 + (hi + lo)/3, the last term by a small reciprocal.
    function automatic logic signed [COORD_W-1:0] move_toward(
        input logic signed [COORD_W-1:0] base,
        input logic signed [COORD_W-1:0] target,
        input logic [2:0]                step,
        input logic [2:0]                ratio
    );
        logic signed [COORD_W:0]   d;
        logic signed [COORD_W+3:0] p;
        logic        [COORD_W+3:0] mag;
        logic        [COORD_W+3:0] n;
        logic        [17:0]        n_hi;
        logic        [17:0]        n_lo;
        logic        [18:0]        n_sum;
        logic        [39:0]        sum_q;
        logic        [COORD_W+3:0] hi_q;
        logic        [COORD_W+3:0] q;
        d     = {target[COORD_W-1], target} - {base[COORD_W-1], base};
        p     = d * $signed({1'b0, step});
        mag   = p[COORD_W+3] ? -p : p;
        n     = mag + 36'd1;
        n_hi  = n[35:18];
        n_lo  = n[17:0];
        n_sum = {1'b0, n_hi} + {1'b0, n_lo};
        sum_q = 40'(n_sum) * 40'd699051;
        hi_q  = 36'(n_hi) * 36'd87381;
        if (ratio == 3'd4)
            q = (mag + 36'd2) >> 2;
        else if (ratio == 3'd2)
            q = (mag + 36'd1) >> 1;
        else
            q = hi_q + 36'(sum_q[39:21]);
        if (p[COORD_W+3])
            move_toward = base - q[COORD_W-1:0];
        else
            move_toward = base + q[COORD_W-1:0];
    endfunction

endpackage

>>> design/lrpd_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module lrpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/lidar_ring_point_densifier.sv
// Top level of the lidar ring point densifier: sequencer, ring-state RAMs.
// Depends on lrpd_pkg and lrpd_ram.
//
//  channel  | dir | payload
//  s_axis   | in  | tdata {stamp,ring_index,brightness,pos_z,pos_y,pos_x}, tuser command
//  m_axis   | out | tdata {out_stamp,out_ring,out_brightness,out_z,out_y,out_x},
//           |     | tuser synthetic, tlast last_of_run
//  cfg      | in  | gap_threshold write
//
// A point passes READ, LOAD, WB and ORIG from acceptance to the next ready; on a
// marked ring the STEP checks and EMIT beats come between LOAD and WB.
// End of frame: READ, LOAD and WB per ring from ring 0 up to the last marked ring,
// plus STEP checks and EMIT beats on a marked ring; each frame beat is held until
// the next shows if it ends the run.
// Reset clears ring marks and control; RAM contents are not cleared.
// A stalled m_axis holds the sequencer; the input waits until the item ends.
module lidar_ring_point_densifier
    import lrpd_pkg::*;
#(
    parameter int RATIO      = RATIO_DEF,
    parameter int RING_COUNT = RING_CNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // pos_x, pos_y, pos_z, brightness, ring_index, stamp
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,  // out_x, out_y, out_z, out_brightness, out_ring, out_stamp
    output logic         m_axis_tuser,  // synthetic
    output logic         m_axis_tlast,  // last_of_run
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata
);

    localparam int RW = $clog2(RING_SLOTS);
    localparam logic [2:0] RATIO_C = 3'(RATIO);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;
    localparam logic [2:0] ST_ORIG  = 3'd6;

    logic [THR_W-1:0] thr_reg;
    logic [2:0]  state_reg;
    logic        cmd_reg;
    pt_t         tgt_reg;
    pt_t         base_reg;
    logic [31:0] bstamp_reg;
    logic [31:0] stamp_reg;
    logic [RW-1:0] ring_reg;
    logic        inrange_reg;
    logic [2:0]  step_reg;
    logic [RING_SLOTS-1:0] seen_reg;
    logic        hold_reg;
    res_t        out_reg;
    logic        ovalid_reg;

    logic [BASE_W-1:0] base_rd, base_wd;
    logic [HEAD_W-1:0] head_rd, head_wd;
    logic              base_we, head_we;
    logic [RW-1:0]     raddr;

    lrpd_ram #(.WIDTH(BASE_W), .DEPTH(RING_SLOTS)) u_base (
        .clk(clk), .we(base_we), .waddr(ring_reg), .wdata(base_wd),
        .raddr(raddr), .rdata(base_rd));

    lrpd_ram #(.WIDTH(HEAD_W), .DEPTH(RING_SLOTS)) u_head (
        .clk(clk), .we(head_we), .waddr(ring_reg), .wdata(head_wd),
        .raddr(raddr), .rdata(head_rd));

    assign raddr = ring_reg;

    logic out_free;
    logic out_load;
    assign out_free      = !ovalid_reg || (m_axis_tvalid && m_axis_tready);
    assign out_load      = ((state_reg == ST_EMIT) || (state_reg == ST_ORIG)) && out_free;
    assign s_axis_tready = (state_reg == ST_IDLE);

    logic [COORD_W:0] gx, gy, gz;
    logic             gap_ok;
    pt_t              moved;
    logic             last_ring;

    function automatic logic [COORD_W:0] absdiff(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        absdiff = d[COORD_W] ? -d : d;
    endfunction

    always_comb
    begin
        gx = absdiff(tgt_reg.x, base_reg.x);
        gy = absdiff(tgt_reg.y, base_reg.y);
        gz = absdiff(tgt_reg.z, base_reg.z);
        gap_ok = (gx <= {2'b0, thr_reg}) && (gy <= {2'b0, thr_reg})
              && (gz <= {2'b0, thr_reg});
        moved.x = move_toward(base_reg.x, tgt_reg.x, step_reg, RATIO_C);
        moved.y = move_toward(base_reg.y, tgt_reg.y, step_reg, RATIO_C);
        moved.z = move_toward(base_reg.z, tgt_reg.z, step_reg, RATIO_C);
        moved.b = move_toward(base_reg.b, tgt_reg.b, step_reg, RATIO_C);
        last_ring = (32'(ring_reg) == RING_COUNT - 1);
    end

    // any later marked ring in frame close
    logic later_seen;
    always_comb
    begin
        later_seen = 1'b0;
        for (int k = 0; k < RING_SLOTS; k++)
        begin
            if (k > int'(ring_reg) && k < RING_COUNT && seen_reg[k])
                later_seen = 1'b1;
        end
    end

    always_comb
    begin
        base_we = 1'b0;
        head_we = 1'b0;
        base_wd = {base_reg, bstamp_reg};
        head_wd = tgt_reg;
        if (state_reg == ST_WB)
        begin
            if (cmd_reg == CMD_POINT)
            begin
                base_we = inrange_reg;
                base_wd = {tgt_reg, stamp_reg};
                head_we = inrange_reg && !seen_reg[ring_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= THR_RESET;
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            ovalid_reg  <= 1'b0;
            cmd_reg     <= CMD_POINT;
            ring_reg    <= '0;
            step_reg    <= 3'd1;
            hold_reg    <= 1'b0;
            inrange_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg     <= s_axis_tuser;
                        tgt_reg.x   <= s_axis_tdata[31:0];
                        tgt_reg.y   <= s_axis_tdata[63:32];
                        tgt_reg.z   <= s_axis_tdata[95:64];
                        tgt_reg.b   <= s_axis_tdata[127:96];
                        stamp_reg   <= s_axis_tdata[163:132];
                        step_reg    <= 3'd1;
                        if (s_axis_tuser == CMD_FRAME)
                        begin
                            ring_reg  <= '0;
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            ring_reg    <= s_axis_tdata[128 +: RW];
                            inrange_reg <= 32'(s_axis_tdata[131:128]) < RING_COUNT;
                            state_reg   <= ST_READ;
                        end
                    end
                end
                ST_READ:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    base_reg   <= base_rd[BASE_W-1:32];
                    bstamp_reg <= base_rd[31:0];
                    if (cmd_reg == CMD_FRAME)
                    begin
                        tgt_reg <= head_rd;
                        if (seen_reg[ring_reg] && 32'(ring_reg) < RING_COUNT)
                            state_reg <= ST_STEP;
                        else
                            state_reg <= ST_WB;
                    end
                    else if (inrange_reg && seen_reg[ring_reg])
                        state_reg <= ST_STEP;
                    else
                        state_reg <= ST_WB;
                end
                ST_STEP:
                begin
                    if (32'(step_reg) >= RATIO)
                        state_reg <= ST_WB;
                    else if (!gap_ok)
                        step_reg <= step_reg + 3'd1;
                    else
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        base_reg        <= moved;
                        out_reg.pt      <= moved;
                        out_reg.ring    <= RING_W'(ring_reg);
                        out_reg.stamp   <= bstamp_reg;
                        out_reg.syn     <= 1'b1;
                        out_reg.last    <= 1'b0;
                        hold_reg        <= (cmd_reg == CMD_FRAME);
                        step_reg        <= step_reg + 3'd1;
                        state_reg       <= ST_STEP;
                    end
                    else if (hold_reg)
                        hold_reg <= 1'b0;
                end
                ST_WB:
                begin
                    if (cmd_reg == CMD_POINT)
                    begin
                        if (inrange_reg)
                            seen_reg[ring_reg] <= 1'b1;
                        state_reg <= ST_ORIG;
                    end
                    else
                    begin
                        if (!later_seen || last_ring || 32'(ring_reg) >= RING_COUNT - 1)
                        begin
                            // close: the held beat ends the run
                            seen_reg <= '0;
                            if (hold_reg)
                            begin
                                out_reg.last <= 1'b1;
                                hold_reg     <= 1'b0;
                            end
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ring_reg  <= ring_reg + 1'b1;
                            step_reg  <= 3'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_ORIG:
                begin
                    if (out_free)
                    begin
                        out_reg.pt    <= tgt_reg;
                        out_reg.ring  <= RING_W'(ring_reg);
                        out_reg.stamp <= stamp_reg;
                        out_reg.syn   <= 1'b0;
                        out_reg.last  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg && !hold_reg;
    assign m_axis_tdata  = {4'b0, out_reg.stamp, out_reg.ring, out_reg.pt.b,
                            out_reg.pt.z, out_reg.pt.y, out_reg.pt.x};
    assign m_axis_tuser  = out_reg.syn;
    assign m_axis_tlast  = out_reg.last;

endmodule

>>> dv/tb_lidar_ring_point_densifier.sv
`timescale 1ns / 1ps
// Self-checking testbench for lidar_ring_point_densifier: a behavioral predictor
// checks every output beat in order. Depends on lrpd_pkg and the design RTL.
module tb_lidar_ring_point_densifier;
    import lrpd_pkg::*;

    localparam int NRATIO = 4;
    localparam int NRINGS = 16;
    localparam int LIMIT  = 400000;

    typedef struct {
        logic [31:0]       x, y, z, b;
        logic [RING_W-1:0] ring;
        logic [31:0]       stamp;
        logic              syn;
        logic              last;
    } beat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         s_axis_tuser = CMD_POINT;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_we = 1'b0;
    logic [30:0]  cfg_wdata = '0;

    lidar_ring_point_densifier DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [30:0]       thr;
    logic signed [31:0] bx[NRINGS], by[NRINGS], bz[NRINGS], bb[NRINGS];
    logic [31:0]       bstamp[NRINGS];
    logic signed [31:0] hx[NRINGS], hy[NRINGS], hz[NRINGS], hb[NRINGS];
    logic              seen[NRINGS];

    beat_t expected_beats[$];
    int    errors = 0;
    int    beats_checked = 0;
    int    points_sent = 0;
    int    frames_sent = 0;
    int    cycles = 0;
    bit    calm = 1'b0;

    function automatic logic signed [31:0] step_toward(logic signed [31:0] base,
                                                       logic signed [31:0] tgt, int i);
        longint p, m, q;
        p = (longint'(tgt) - longint'(base)) * i;
        m = p < 0 ? -p : p;
        q = (m + NRATIO / 2) / NRATIO;
        return 32'(longint'(base) + (p < 0 ? -q : q));
    endfunction

    function automatic longint gap(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d < 0 ? -d : d;
    endfunction

    function automatic void push_beat(logic [31:0] x, y, z, b, logic [3:0] r,
                                      logic [31:0] st, logic syn);
        beat_t e;
        e.x = x; e.y = y; e.z = z; e.b = b;
        e.ring = r; e.stamp = st; e.syn = syn; e.last = 1'b0;
        expected_beats.push_back(e);
    endfunction

    function automatic void densify(int r, logic signed [31:0] tx, ty, tz, tb);
        for (int i = 1; i < NRATIO; i++)
        begin
            if (gap(tx, bx[r]) > thr || gap(ty, by[r]) > thr || gap(tz, bz[r]) > thr)
                continue;
            bx[r] = step_toward(bx[r], tx, i);
            by[r] = step_toward(by[r], ty, i);
            bz[r] = step_toward(bz[r], tz, i);
            bb[r] = step_toward(bb[r], tb, i);
            push_beat(bx[r], by[r], bz[r], bb[r], r[3:0], bstamp[r], 1'b1);
        end
    endfunction

    function automatic void predict(logic cmd, logic signed [31:0] x, y, z, b,
                                    logic [3:0] r, logic [31:0] st);
        int n0;
        n0 = expected_beats.size();
        if (cmd == CMD_FRAME)
        begin
            for (int k = 0; k < NRINGS; k++)
                if (seen[k]) densify(k, hx[k], hy[k], hz[k], hb[k]);
            for (int k = 0; k < NRINGS; k++) seen[k] = 1'b0;
        end
        else
        begin
            if (seen[r]) densify(r, x, y, z, b);
            else
            begin
                hx[r] = x; hy[r] = y; hz[r] = z; hb[r] = b;
                seen[r] = 1'b1;
            end
            bx[r] = x; by[r] = y; bz[r] = z; bb[r] = b; bstamp[r] = st;
            push_beat(x, y, z, b, r, st, 1'b0);
        end
        if (expected_beats.size() > n0)
            expected_beats[expected_beats.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got,
                 want);
    endtask

    task automatic send_item(logic cmd, logic [31:0] x, y, z, b, logic [3:0] r,
                             logic [31:0] st);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tdata  <= {4'b0, st, r, b, z, y, x};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict(cmd, x, y, z, b, r, st);
        if (cmd == CMD_FRAME) frames_sent++; else points_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (2 * NRINGS * (NRATIO + 3)) @(negedge clk);
    endtask

    task automatic write_threshold(logic [30:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        thr = v;
    endtask

    task automatic send_point(logic [31:0] x, y, z, b, logic [3:0] r);
        send_item(CMD_POINT, x, y, z, b, r, $urandom);
    endtask

    task automatic send_frame_end();
        send_item(CMD_FRAME, $urandom, $urandom, $urandom, $urandom, 4'($urandom), $urandom);
    endtask

    // output side
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat x", m_axis_tdata[31:0], 32'd0);
            else
            begin
                beat_t e;
                e = expected_beats.pop_front();
                if (m_axis_tdata[31:0] !== e.x) report_mismatch("x", m_axis_tdata[31:0], e.x);
                if (m_axis_tdata[63:32] !== e.y)
                    report_mismatch("y", m_axis_tdata[63:32], e.y);
                if (m_axis_tdata[95:64] !== e.z)
                    report_mismatch("z", m_axis_tdata[95:64], e.z);
                if (m_axis_tdata[127:96] !== e.b)
                    report_mismatch("brightness", m_axis_tdata[127:96], e.b);
                if (m_axis_tdata[131:128] !== e.ring)
                    report_mismatch("ring", 32'(m_axis_tdata[131:128]), 32'(e.ring));
                if (m_axis_tdata[163:132] !== e.stamp)
                    report_mismatch("stamp", m_axis_tdata[163:132], e.stamp);
                if (m_axis_tdata[167:164] !== 4'd0)
                    report_mismatch("pad", 32'(m_axis_tdata[167:164]), 32'd0);
                if (m_axis_tuser !== e.syn)
                    report_mismatch("synthetic", 32'(m_axis_tuser), 32'(e.syn));
                if (m_axis_tlast !== e.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(e.last));
                beats_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (calm || $urandom_range(0, 3) != 0) m_axis_tready <= 1'b1;
        else m_axis_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic test_extremes();
        send_point(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff, 4'd0);
        send_point(32'h80000000, 32'h7fffffff, 32'h0, 32'h80000000, 4'd0);
        send_point(32'h80000000, 32'h7fffffff, 32'h1, 32'h7fffffff, 4'd0);
        send_point(32'h10000, 32'h10000, 32'h10000, 32'h0, 4'd15);
        send_point(32'h0, 32'h0, 32'h0, 32'hffffffff, 4'd15);
        send_point(32'h3, 32'hfffffffd, 32'h10001, 32'h5, 4'd15);
        send_frame_end();
        send_frame_end();
    endtask

    task automatic test_rounding();
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 4'd7);
        send_point(32'h2, 32'hfffffffe, 32'h1, 32'hffffffff, 4'd7);
        send_point(32'h6, 32'hfffffffa, 32'h3, 32'h7, 4'd7);
        send_point(32'h10000, 32'hffff0000, 32'h0, 32'h9, 4'd8);
        send_frame_end();
    endtask

    task automatic test_threshold(logic [30:0] v, int n, int span);
        logic [31:0] cx[NRINGS], cy[NRINGS], cz[NRINGS];
        logic [3:0]  r;
        write_threshold(v);
        for (int k = 0; k < NRINGS; k++)
        begin
            cx[k] = $urandom; cy[k] = $urandom; cz[k] = $urandom;
        end
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
            begin
                send_point($urandom, $urandom, $urandom, $urandom, r);
            end
            else
            begin
                cx[r] = near(cx[r], span); cy[r] = near(cy[r], span);
                cz[r] = near(cz[r], span);
                send_point(cx[r], cy[r], cz[r], $urandom, r);
            end
            if ($urandom_range(0, 11) == 0) send_frame_end();
        end
        send_frame_end();
    endtask

    initial
    begin
        thr = THR_RESET;
        for (int k = 0; k < NRINGS; k++) seen[k] = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_rounding();
        test_threshold(31'h7fffffff, 15, 32'h40000000);
        test_threshold(31'd0, 10, 1);
        test_threshold(31'h20000, 20, 32'h30000);
        test_threshold(THR_RESET, 20, 32'h14000);
        drain();
        calm = 1'b1;
        test_threshold(31'h8000, 20, 32'ha000);
        drain();
        $display("covered %0d points and %0d frame ends, %0d output beats checked",
                 points_sent, frames_sent, beats_checked);
        $display("thresholds from zero to full scale, ring indexes 0..15");
        if (errors == 0 && expected_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
